>>> sv/mixed_radix_code_indexer_core_defines.svh
// Assertion macros for the mixed-radix code indexer.
// Included by mixed_radix_code_indexer_core, which carries the assertions; depends on nothing else.
`ifndef MIXED_RADIX_CODE_INDEXER_CORE_DEFINES_SVH
`define MIXED_RADIX_CODE_INDEXER_CORE_DEFINES_SVH

// Check that a consequent holds in the same cycle as its antecedent
`define MRCI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent
`define MRCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

>>> sv/mrci_pkg.sv
// Shared types and constants for the mixed-radix code indexer.
// Used by mrci_cell and mixed_radix_code_indexer_core; depends on nothing.
package mrci_pkg;

  // Bytes in a code and the width of the internal code words
  localparam int CODE_BYTES = 4;
  localparam int CODE_W     = CODE_BYTES * 8;

  // Input register, one cell per byte, output register
  localparam int LATENCY = CODE_BYTES + 2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_MAX = 2'd1;

  localparam logic [31:0] DIGIT_MIN_RESET = 32'h0000_0000;
  localparam logic [31:0] DIGIT_MAX_RESET = 32'h0000_FFFF;

  // Step status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_EDGE = 2'd1;
  localparam logic [1:0] STAT_WRAP = 2'd2;

  // One beat moving along the chain of byte cells
  typedef struct packed {
    logic              vld;
    logic              eq_first;
    logic              eq_last;
    logic              err;
    logic              borrow;
    logic              carry;
    logic              dec_borrow;
    logic [31:0]       weight;
    logic [31:0]       acc;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] lo;
    logic [CODE_W-1:0] hi;
    logic [CODE_W-1:0] nxt;
    logic [CODE_W-1:0] prv;
  } mrci_beat_t;

endpackage

>>> sv/mrci_cell.sv
// One byte cell of the indexer chain: works on byte 0 of each word it receives.
// Depends on mrci_pkg; hands the shifted words on to the next cell every cycle.
module mrci_cell (
  input  logic                clk,
  input  logic                rst,
  input  mrci_pkg::mrci_beat_t beat_in,
  output mrci_pkg::mrci_beat_t beat_out
);

  mrci_pkg::mrci_beat_t beat_next;

  logic [7:0] c_byte;
  logic [7:0] f_byte;
  logic [7:0] lo_byte;
  logic [7:0] hi_byte;
  logic       range_err;
  logic [9:0] diff;
  logic [9:0] radix;
  logic [9:0] diff_adj;
  logic [7:0] inc_byte;
  logic       inc_carry;
  logic [7:0] dec_byte;
  logic       dec_borrow;

  assign c_byte  = beat_in.code[7:0];
  assign f_byte  = beat_in.first[7:0];
  assign lo_byte = beat_in.lo[7:0];
  assign hi_byte = beat_in.hi[7:0];

  // Check the byte against its limits and form the signed digit difference
  always_comb begin
    range_err = (c_byte < lo_byte) || (c_byte > hi_byte);
    diff      = {2'b00, c_byte} - {9'd0, beat_in.borrow} - {2'b00, f_byte};
    radix     = {2'b00, hi_byte} - {2'b00, lo_byte} + 10'd1;
    diff_adj  = diff[9] ? (diff + radix) : diff;
  end

  // Raise the byte by one when a carry arrives, wrapping to the lower limit
  always_comb begin
    inc_byte  = c_byte;
    inc_carry = 1'b0;
    if (beat_in.carry) begin
      if (c_byte >= hi_byte) begin
        inc_byte  = lo_byte;
        inc_carry = 1'b1;
      end else begin
        inc_byte  = c_byte + 8'd1;
      end
    end
  end

  // Lower the byte by one when a borrow arrives, wrapping to the upper limit
  always_comb begin
    dec_byte   = c_byte;
    dec_borrow = 1'b0;
    if (beat_in.dec_borrow) begin
      if (c_byte <= lo_byte) begin
        dec_byte   = hi_byte;
        dec_borrow = 1'b1;
      end else begin
        dec_byte   = c_byte - 8'd1;
      end
    end
  end

  // Assemble the beat for the next cell: consume byte 0, rotate results in at the top
  always_comb begin
    beat_next            = beat_in;
    beat_next.err        = beat_in.err | range_err;
    beat_next.borrow     = diff[9];
    beat_next.acc        = beat_in.acc + ({{22{diff_adj[9]}}, diff_adj} * beat_in.weight);
    beat_next.weight     = beat_in.weight * {{22{radix[9]}}, radix};
    beat_next.carry      = inc_carry;
    beat_next.dec_borrow = dec_borrow;
    beat_next.code  = (beat_in.code >> 8)
                    | (mrci_pkg::CODE_W'(c_byte) << (mrci_pkg::CODE_W - 8));
    beat_next.first = beat_in.first >> 8;
    beat_next.lo    = beat_in.lo >> 8;
    beat_next.hi    = beat_in.hi >> 8;
    beat_next.nxt   = (beat_in.nxt >> 8)
                    | (mrci_pkg::CODE_W'(inc_byte) << (mrci_pkg::CODE_W - 8));
    beat_next.prv   = (beat_in.prv >> 8)
                    | (mrci_pkg::CODE_W'(dec_byte) << (mrci_pkg::CODE_W - 8));
  end

  // Register the beat; clear it on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out <= '0;
    end else begin
      beat_out <= beat_next;
    end
  end

endmodule

>>> sv/mixed_radix_code_indexer_core.sv
// Mixed-radix code indexer: offset, next code and previous code of one code.
// Throughput: one code per cycle; busy stays low, every start is taken.
// The chain has one cell per code byte after an input register, then an output register.
// Reset (rst, synchronous) clears the pipeline valid marks and restores the limit registers.
// done marks each result for one cycle; the receiver cannot stall.
`include "mixed_radix_code_indexer_core_defines.svh"

module mixed_radix_code_indexer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [31:0]                         code,
  input  logic [31:0]                         area_first,
  input  logic [31:0]                         area_last,
  input  logic                                use_area_limits,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrci_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data,
  output logic                                done,
  output logic [31:0]                         offset,
  output logic                                offset_error,
  output logic [31:0]                         next_code_out,
  output logic [1:0]                          next_status,
  output logic [31:0]                         previous_code_out,
  output logic [1:0]                          previous_status
);

  logic [31:0] digit_min;
  logic [31:0] digit_max;

  mrci_pkg::mrci_beat_t beat_in_next;
  mrci_pkg::mrci_beat_t head;
  mrci_pkg::mrci_beat_t chain [mrci_pkg::CODE_BYTES+1];
  mrci_pkg::mrci_beat_t tail;

  logic [31:0] lo_sel;
  logic [31:0] hi_sel;
  logic        err_final;
  logic [31:0] code_final;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Write the limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_min <= mrci_pkg::DIGIT_MIN_RESET;
      digit_max <= mrci_pkg::DIGIT_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrci_pkg::REG_DIGIT_MIN: digit_min <= cfg_data;
        mrci_pkg::REG_DIGIT_MAX: digit_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the limits and seed the chain
  always_comb begin
    lo_sel = use_area_limits ? area_first : digit_min;
    hi_sel = use_area_limits ? area_last  : digit_max;
    beat_in_next.vld        = start && !busy;
    beat_in_next.eq_first   = (code == area_first);
    beat_in_next.eq_last    = (code == area_last);
    beat_in_next.err        = (code > area_last) || (code < area_first);
    beat_in_next.borrow     = 1'b0;
    beat_in_next.carry      = 1'b1;
    beat_in_next.dec_borrow = 1'b1;
    beat_in_next.weight     = 32'd1;
    beat_in_next.acc        = 32'd0;
    beat_in_next.code       = mrci_pkg::CODE_W'(code);
    beat_in_next.first      = mrci_pkg::CODE_W'(area_first);
    beat_in_next.lo         = mrci_pkg::CODE_W'(lo_sel);
    beat_in_next.hi         = mrci_pkg::CODE_W'(hi_sel);
    beat_in_next.nxt        = '0;
    beat_in_next.prv        = '0;
  end

  // Register the incoming beat; clear it on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= beat_in_next;
    end
  end

  assign chain[0] = head;

  // One cell per code byte
  for (genvar g = 0; g < mrci_pkg::CODE_BYTES; g++) begin : g_cell
    mrci_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .beat_in  (chain[g]),
      .beat_out (chain[g+1])
    );
  end

  assign tail       = chain[mrci_pkg::CODE_BYTES];
  assign err_final  = tail.err | tail.borrow;
  assign code_final = 32'(tail.code);

  // Register the result and mark it with done
  always_ff @(posedge clk) begin
    offset            <= err_final ? 32'd0 : tail.acc;
    offset_error      <= err_final;
    next_code_out     <= (tail.eq_last || tail.carry) ? code_final : 32'(tail.nxt);
    previous_code_out <= (tail.eq_first || tail.dec_borrow) ? code_final : 32'(tail.prv);
    priority if (tail.eq_last) begin
      next_status <= mrci_pkg::STAT_EDGE;
    end else if (tail.carry) begin
      next_status <= mrci_pkg::STAT_WRAP;
    end else begin
      next_status <= mrci_pkg::STAT_OK;
    end
    priority if (tail.eq_first) begin
      previous_status <= mrci_pkg::STAT_EDGE;
    end else if (tail.dec_borrow) begin
      previous_status <= mrci_pkg::STAT_WRAP;
    end else begin
      previous_status <= mrci_pkg::STAT_OK;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.vld;
    end
  end

  `MRCI_ASSERT_SAME(a_offset_zero_on_error, done && offset_error, offset == 32'd0, "offset not zero on error")
  `MRCI_ASSERT_SAME(a_result_latency, start && !busy, ##(mrci_pkg::LATENCY) done, "result missing after fixed latency")
  `MRCI_ASSERT_SAME(a_edges_keep_code, done && next_status == mrci_pkg::STAT_EDGE && previous_status == mrci_pkg::STAT_EDGE, next_code_out == previous_code_out, "edge results disagree on code")
  `MRCI_ASSERT_NEXT(a_cfg_max_write, cfg_valid && cfg_ready && cfg_index == mrci_pkg::REG_DIGIT_MAX, digit_max == $past(cfg_data), "digit_max write lost")

endmodule

>>> sim/tb_mixed_radix_code_indexer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for mixed_radix_code_indexer_core: offset, next and previous code.
// Depends on mrci_pkg and the core; a built-in predictor checks every result beat.
module tb_mixed_radix_code_indexer_core;

  // Spare register indexes: writes to these must leave the limits untouched
  localparam logic [mrci_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [mrci_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  // Expected content of one result beat
  typedef struct packed {
    logic [31:0] ofs;
    logic        ofs_err;
    logic [31:0] nxt;
    logic [1:0]  nxt_stat;
    logic [31:0] prv;
    logic [1:0]  prv_stat;
  } code_index_t;

  logic                             clk;
  logic                             rst;
  logic                             start;
  logic                             busy;
  logic [31:0]                      code;
  logic [31:0]                      area_first;
  logic [31:0]                      area_last;
  logic                             use_area_limits;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [mrci_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]                      cfg_data;
  logic                             done;
  logic [31:0]                      offset;
  logic                             offset_error;
  logic [31:0]                      next_code_out;
  logic [1:0]                       next_status;
  logic [31:0]                      previous_code_out;
  logic [1:0]                       previous_status;

  // Shadow copies of the limit registers
  logic [31:0] lim_min;
  logic [31:0] lim_max;

  code_index_t index_q[$];
  int          n_fail;
  bit          burst_mode;

  mixed_radix_code_indexer_core dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .code              (code),
    .area_first        (area_first),
    .area_last         (area_last),
    .use_area_limits   (use_area_limits),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .done              (done),
    .offset            (offset),
    .offset_error      (offset_error),
    .next_code_out     (next_code_out),
    .next_status       (next_status),
    .previous_code_out (previous_code_out),
    .previous_status   (previous_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Work out offset, next and previous code for one code under the current limits
  function automatic code_index_t index_code(input logic [31:0] c, input logic [31:0] f,
                                             input logic [31:0] l, input logic area);
    code_index_t r;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    longint      acc;
    longint      weight;
    int          d;
    int          radix;
    int          borrow;
    bit          bad;
    bit          stepping;
    lo = area ? f : lim_min;
    hi = area ? l : lim_max;

    // Range checks: whole code against the area, each byte against its limits
    bad = (c > l) || (c < f);
    for (int i = 0; i < mrci_pkg::CODE_BYTES; i++) begin
      if (c[8*i +: 8] < lo[8*i +: 8] || c[8*i +: 8] > hi[8*i +: 8])
        bad = 1'b1;
    end

    // Signed digit differences with borrow; a borrow out of the top byte is an error
    acc = 0;
    weight = 1;
    borrow = 0;
    stepping = !bad;
    for (int i = 0; i < mrci_pkg::CODE_BYTES; i++) begin
      if (stepping) begin
        radix = int'(hi[8*i +: 8]) - int'(lo[8*i +: 8]) + 1;
        d = int'(c[8*i +: 8]) - borrow - int'(f[8*i +: 8]);
        if (d < 0 && i == mrci_pkg::CODE_BYTES - 1) begin
          bad = 1'b1;
          stepping = 1'b0;
        end else begin
          if (d < 0) begin
            borrow = 1;
            d = d + radix;
          end else begin
            borrow = 0;
          end
          acc = acc + longint'(d) * weight;
          weight = weight * longint'(radix);
        end
      end
    end
    r.ofs = bad ? 32'd0 : 32'(acc);
    r.ofs_err = bad;

    // Next code: raise the lowest byte that has room, wrap the ones below
    r.nxt = c;
    if (c == l) begin
      r.nxt_stat = mrci_pkg::STAT_EDGE;
    end else begin
      t = c;
      r.nxt_stat = mrci_pkg::STAT_WRAP;
      stepping = 1'b1;
      for (int i = 0; i < mrci_pkg::CODE_BYTES; i++) begin
        if (stepping) begin
          if (int'(t[8*i +: 8]) + 1 > int'(hi[8*i +: 8])) begin
            t[8*i +: 8] = lo[8*i +: 8];
          end else begin
            t[8*i +: 8] = t[8*i +: 8] + 8'd1;
            r.nxt_stat = mrci_pkg::STAT_OK;
            stepping = 1'b0;
          end
        end
      end
      if (r.nxt_stat == mrci_pkg::STAT_OK) r.nxt = t;
    end

    // Previous code: lower the lowest byte above its floor, wrap the ones below
    r.prv = c;
    if (c == f) begin
      r.prv_stat = mrci_pkg::STAT_EDGE;
    end else begin
      t = c;
      r.prv_stat = mrci_pkg::STAT_WRAP;
      stepping = 1'b1;
      for (int i = 0; i < mrci_pkg::CODE_BYTES; i++) begin
        if (stepping) begin
          if (int'(t[8*i +: 8]) - 1 < int'(lo[8*i +: 8])) begin
            t[8*i +: 8] = hi[8*i +: 8];
          end else begin
            t[8*i +: 8] = t[8*i +: 8] - 8'd1;
            r.prv_stat = mrci_pkg::STAT_OK;
            stepping = 1'b0;
          end
        end
      end
      if (r.prv_stat == mrci_pkg::STAT_OK) r.prv = t;
    end
    return r;
  endfunction

  // Byte inside [lo, hi], biased towards the edges; any byte if the range is empty
  function automatic logic [7:0] pick_byte(input logic [7:0] lo, input logic [7:0] hi);
    int r;
    r = $urandom_range(0, 3);
    if (lo > hi) return 8'($urandom_range(0, 255));
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 8'($urandom_range(int'(lo), int'(hi)));
  endfunction

  function automatic logic [31:0] legal_code(input logic [31:0] lo, input logic [31:0] hi);
    logic [31:0] r;
    for (int i = 0; i < mrci_pkg::CODE_BYTES; i++)
      r[8*i +: 8] = pick_byte(lo[8*i +: 8], hi[8*i +: 8]);
    return r;
  endfunction

  // Area with first byte <= last byte everywhere; some bytes get a narrow span
  function automatic logic [63:0] random_area();
    logic [31:0] f;
    logic [31:0] l;
    int          fb;
    int          span;
    for (int i = 0; i < mrci_pkg::CODE_BYTES; i++) begin
      fb = $urandom_range(0, 255);
      span = $urandom_range(0, 1) ? 255 - fb : ((255 - fb) < 3 ? 255 - fb : 3);
      f[8*i +: 8] = 8'(fb);
      l[8*i +: 8] = 8'(fb + $urandom_range(0, span));
    end
    return {l, f};
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      n_fail++;
    end
  endtask

  // Compare each result beat with the oldest pending expectation
  always @(posedge clk) begin : check_results
    code_index_t want;
    if (!rst && done) begin
      if (index_q.size() == 0) begin
        $error("result beat with no code pending");
        n_fail++;
      end else begin
        want = index_q.pop_front();
        check_field("offset", want.ofs, offset);
        check_field("offset_error", 32'(want.ofs_err), 32'(offset_error));
        check_field("next_code_out", want.nxt, next_code_out);
        check_field("next_status", 32'(want.nxt_stat), 32'(next_status));
        check_field("previous_code_out", want.prv, previous_code_out);
        check_field("previous_status", 32'(want.prv_stat), 32'(previous_status));
      end
    end
  end

  // Send one code; hold start high across beats unless a gap is drawn
  task automatic send_code(input logic [31:0] c, input logic [31:0] f,
                           input logic [31:0] l, input logic area);
    int gap;
    gap = 0;
    if (!burst_mode && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    code <= c;
    area_first <= f;
    area_last <= l;
    use_area_limits <= area;
    do @(posedge clk); while (busy);
    index_q.push_back(index_code(c, f, l, area));
  endtask

  // Drop start and wait until every pending result has come back
  task automatic settle_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (index_q.size() != 0) @(posedge clk);
    repeat (mrci_pkg::LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [mrci_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
    settle_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == mrci_pkg::REG_DIGIT_MIN) lim_min = data;
    else if (idx == mrci_pkg::REG_DIGIT_MAX) lim_max = data;
  endtask

  // Mostly well-formed codes in either mode, the rest raw noise
  task automatic run_random(input int n);
    int          kind;
    int          r;
    logic [31:0] c;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] f;
    logic [31:0] l;
    logic [63:0] span;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      r = $urandom_range(0, 99);
      if (kind < 45) begin
        c = legal_code(lim_min, lim_max);
        a = legal_code(lim_min, lim_max);
        b = legal_code(lim_min, lim_max);
        f = (a < c) ? a : c;
        l = (b > c) ? b : c;
        if (r < 10) f = c;
        else if (r < 20) l = c;
        send_code(c, f, l, 1'b0);
      end else if (kind < 80) begin
        span = random_area();
        f = span[31:0];
        l = span[63:32];
        c = legal_code(f, l);
        if (r < 10) c = f;
        else if (r < 20) c = l;
        send_code(c, f, l, 1'b1);
      end else begin
        send_code($urandom, $urandom, $urandom, 1'(($urandom_range(0, 1))));
      end
    end
  endtask

  // Reset limits: bytes 0..1 full range, bytes 2..3 pinned at zero
  task automatic test_reset_limits();
    send_code(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_code(32'h0000_FFFF, 32'h0000_0000, 32'h0000_FFFF, 1'b0);
    send_code(32'h0000_00FF, 32'h0000_0000, 32'h0000_FFFF, 1'b0);
    send_code(32'h0000_0100, 32'h0000_0000, 32'h0000_FFFF, 1'b0);
    send_code(32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_code(32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 1'b0);
    send_code(32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_code(32'h0000_0100, 32'h0000_00FF, 32'h0000_FFFF, 1'b0);
    send_code(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_code(32'h0000_1234, 32'h0000_1234, 32'h0000_1234, 1'b0);
    run_random(150);
  endtask

  // Area mode: limits taken from the area's first and last codes
  task automatic test_area_limits();
    send_code(32'h1A2B_3C4D, 32'h1020_3040, 32'h1F2F_3F4F, 1'b1);
    send_code(32'h1020_3040, 32'h1020_3040, 32'h1F2F_3F4F, 1'b1);
    send_code(32'h1F2F_3F4F, 32'h1020_3040, 32'h1F2F_3F4F, 1'b1);
    send_code(32'h1020_3050, 32'h1020_3040, 32'h1F2F_3F4F, 1'b1);
    send_code(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_code(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    send_code(32'h0000_0080, 32'h0000_0090, 32'h0000_0070, 1'b1);
    run_random(100);
  endtask

  task automatic test_full_limits();
    write_limit(mrci_pkg::REG_DIGIT_MIN, 32'h0000_0000);
    write_limit(mrci_pkg::REG_DIGIT_MAX, 32'hFFFF_FFFF);
    send_code(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0);
    send_code(32'h00FF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    run_random(150);
  endtask

  // Every byte empty: register mode always errors, stepping still wraps
  task automatic test_empty_limits();
    write_limit(mrci_pkg::REG_DIGIT_MIN, 32'hFFFF_FFFF);
    write_limit(mrci_pkg::REG_DIGIT_MAX, 32'h0000_0000);
    send_code(32'h8000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    run_random(100);
  endtask

  // Narrow window; includes an unbroken burst and a full drain in the middle
  task automatic test_window_limits();
    write_limit(mrci_pkg::REG_DIGIT_MIN, 32'h1020_3040);
    write_limit(mrci_pkg::REG_DIGIT_MAX, 32'h1F2F_3F4F);
    send_code(32'h1020_3040, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_code(32'h1F2F_3F4F, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    burst_mode = 1'b1;
    run_random(100);
    burst_mode = 1'b0;
    settle_pipeline();
    run_random(100);
  endtask

  // Radix one in every byte
  task automatic test_single_value_limits();
    write_limit(mrci_pkg::REG_DIGIT_MIN, 32'h55AA_33CC);
    write_limit(mrci_pkg::REG_DIGIT_MAX, 32'h55AA_33CC);
    send_code(32'h55AA_33CC, 32'h55AA_33CC, 32'h55AA_33CC, 1'b0);
    run_random(80);
  endtask

  // Random limit pairs; the last setting may leave some bytes empty
  task automatic test_random_limits();
    logic [31:0] a;
    logic [31:0] b;
    logic [7:0]  tmp;
    for (int s = 0; s < 4; s++) begin
      a = $urandom;
      b = $urandom;
      for (int i = 0; i < mrci_pkg::CODE_BYTES; i++) begin
        if (s < 3 && a[8*i +: 8] > b[8*i +: 8]) begin
          tmp = a[8*i +: 8];
          a[8*i +: 8] = b[8*i +: 8];
          b[8*i +: 8] = tmp;
        end
        if (s == 1) b[8*i +: 8] = (a[8*i +: 8] > 8'd252) ? 8'hFF : a[8*i +: 8] + 8'd3;
      end
      write_limit(mrci_pkg::REG_DIGIT_MIN, a);
      write_limit(mrci_pkg::REG_DIGIT_MAX, b);
      run_random(50);
    end
  endtask

  // Writes to unused indexes must be ignored
  task automatic test_spare_indexes();
    write_limit(mrci_pkg::REG_DIGIT_MIN, 32'h0001_0203);
    write_limit(mrci_pkg::REG_DIGIT_MAX, 32'h0F1F_2F3F);
    write_limit(REG_SPARE_A, $urandom);
    write_limit(REG_SPARE_B, $urandom);
    run_random(50);
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    code <= '0;
    area_first <= '0;
    area_last <= '0;
    use_area_limits <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= mrci_pkg::REG_DIGIT_MIN;
    cfg_data <= '0;
    lim_min = mrci_pkg::DIGIT_MIN_RESET;
    lim_max = mrci_pkg::DIGIT_MAX_RESET;
    n_fail = 0;
    burst_mode = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_limits();
    test_area_limits();
    test_full_limits();
    test_empty_limits();
    test_window_limits();
    test_single_value_limits();
    test_random_limits();
    test_spare_indexes();

    // Drain and let any stray beat show up before the verdict
    settle_pipeline();
    repeat (mrci_pkg::LATENCY + 4) @(posedge clk);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
